// ----- src/wbps_pkg.sv -----
package wbps_pkg;

   localparam int unsigned DATA_W       = 8;
   localparam int unsigned OUT_OFFSET_W = 32;
   localparam int unsigned CSR_DATA_W   = 64;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned LEN_REG_W    = 5;
   localparam int unsigned MASK_W       = 16;
   localparam int unsigned REG_BYTES    = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WILDCARD     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LENGTH       = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              region_end;
   } req_payload_type;

   typedef struct packed {
      logic                    found;
      logic [OUT_OFFSET_W-1:0] match_offset;
      logic                    offset_overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] pattern_low;
      logic [CSR_DATA_W-1:0] pattern_high;
      logic [MASK_W-1:0]     wildcard_mask;
      logic [LEN_REG_W-1:0]  pattern_length;
   } cfg_type;

   // positions beyond the two pattern registers must match a zero byte
   function automatic logic [DATA_W-1:0] pattern_at(input cfg_type cfg, input int pos);
      logic [DATA_W-1:0] b;
      b = '0;
      if (pos < REG_BYTES) begin
         b = cfg.pattern_low[pos*DATA_W +: DATA_W];
      end else if (pos < 2*REG_BYTES) begin
         b = cfg.pattern_high[(pos-REG_BYTES)*DATA_W +: DATA_W];
      end
      return b;
   endfunction

   function automatic logic wild_at(input cfg_type cfg, input int pos);
      logic w;
      w = 1'b0;
      if (pos < MASK_W) begin
         w = cfg.wildcard_mask[pos];
      end
      return w;
   endfunction

endpackage

// ----- src/wbps_window_match.sv -----
module wbps_window_match #(
   parameter int MAX_PATTERN = 16
) (
   input  wbps_pkg::cfg_type                                  cfg,
   input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN+1) : 1)-1:0] len,
   // entry 0 is the byte in flight, entry k the byte k positions older
   input  logic [MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0]      window,
   output logic                                               match
);

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [MAX_PATTERN-1:0] pos_ok;

   always_comb begin
      logic [IDX_W-1:0] sel;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         sel = IDX_W'(int'(len) - 1 - i);
         if (i >= int'(len)) begin
            pos_ok[i] = 1'b1;
         end else if (wbps_pkg::wild_at(cfg, i)) begin
            pos_ok[i] = 1'b1;
         end else begin
            pos_ok[i] = (window[sel] == wbps_pkg::pattern_at(cfg, i));
         end
      end
   end

   assign match = &pos_ok;

endmodule

// ----- src/wildcard_byte_pattern_search_unit.sv -----
// Wildcard byte signature scanner.
// Request channel (req_valid/req_stall/req_payload) carries one byte of the
// scanned region per transaction, with region_end on the last byte. The
// response channel (rsp_valid/rsp_stall/rsp_payload) carries at most one
// transaction per region: found with the start offset of the first match, or
// not-found on the region's last byte. Bytes after a match are dropped until
// region_end, which then clears the region state.
// The csr_ port writes pattern bytes, wildcard mask and pattern length; write
// it only while the block is idle.
// A byte in the input register is compared combinationally against the byte
// window, and its response, if any, is written to the response register.
// Throughput: one byte per cycle unless a stalled response holds the input.
// Reset clears the region state and loads the register reset values; no
// clearing sweep is needed. When rsp_stall holds a pending response, the input
// register still takes one more byte, then req_stall rises until it drains.
module wildcard_byte_pattern_search_unit #(
   parameter int MAX_PATTERN = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  wbps_pkg::req_payload_type                req_payload,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output wbps_pkg::rsp_payload_type                rsp_payload,
   input  logic                                     csr_write_en,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int LEN_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN+1) : 1;
   localparam int WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

   wbps_pkg::cfg_type cfg_ff, cfg_in;

   logic                      s1_valid_ff, s1_valid_in;
   wbps_pkg::req_payload_type s1_data_ff, s1_data_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   wbps_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [WIN_D-1:0][wbps_pkg::DATA_W-1:0] win_ff, win_in;
   logic [OFFSET_BITS-1:0]                 count_ff, count_in;
   logic                                   reported_ff, reported_in;

   logic [LEN_W-1:0]                              len_eff;
   logic [LEN_W-1:0]                              len_m1;
   logic [MAX_PATTERN-1:0][wbps_pkg::DATA_W-1:0]  window;
   logic                                          window_match;
   logic                                          advance;
   logic                                          s1_fire;
   logic                                          enough;
   logic                                          hit;
   logic [OFFSET_BITS-1:0]                        start;
   logic                                          ovf;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            wbps_pkg::CSR_PATTERN_LOW:  cfg_in.pattern_low    = csr_wdata;
            wbps_pkg::CSR_PATTERN_HIGH: cfg_in.pattern_high   = csr_wdata;
            wbps_pkg::CSR_WILDCARD:     cfg_in.wildcard_mask  = csr_wdata[wbps_pkg::MASK_W-1:0];
            wbps_pkg::CSR_LENGTH:       cfg_in.pattern_length = csr_wdata[wbps_pkg::LEN_REG_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      if (cfg_ff.pattern_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (8'(cfg_ff.pattern_length) > 8'(MAX_PATTERN)) begin
         len_eff = LEN_W'(MAX_PATTERN);
      end else begin
         len_eff = LEN_W'(cfg_ff.pattern_length);
      end
   end

   assign len_m1 = len_eff - LEN_W'(1);

   // handshake
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_valid && !req_stall) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_payload;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // window as seen by the byte in the input register
   always_comb begin
      window[0] = s1_data_ff.data_byte;
      for (int k = 1; k < MAX_PATTERN; k++) begin
         window[k] = win_ff[k-1];
      end
   end

   wbps_window_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .cfg    (cfg_ff),
      .len    (len_eff),
      .window (window),
      .match  (window_match)
   );

   assign enough = (count_ff >= OFFSET_BITS'(len_m1));
   assign hit    = !reported_ff && enough && window_match;
   assign start  = count_ff - OFFSET_BITS'(len_m1);
   assign ovf    = (count_ff == '1) ||
                   ((OFFSET_BITS > wbps_pkg::OUT_OFFSET_W) &&
                    (|(start >> wbps_pkg::OUT_OFFSET_W)));

   // region state
   always_comb begin
      win_in      = win_ff;
      count_in    = count_ff;
      reported_in = reported_ff;
      if (s1_fire) begin
         if (!reported_ff) begin
            for (int k = WIN_D - 1; k > 0; k--) begin
               win_in[k] = win_ff[k-1];
            end
            win_in[0] = s1_data_ff.data_byte;
            if (count_ff != '1) begin
               count_in = count_ff + OFFSET_BITS'(1);
            end
            if (hit) begin
               reported_in = 1'b1;
            end
         end
         if (s1_data_ff.region_end) begin
            count_in    = '0;
            reported_in = 1'b0;
         end
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire && !reported_ff && (hit || s1_data_ff.region_end)) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.found           = hit;
         rsp_data_in.match_offset    = hit ? wbps_pkg::OUT_OFFSET_W'(start) : '0;
         rsp_data_in.offset_overflow = hit && ovf;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.wildcard_mask  <= '0;
         cfg_ff.pattern_length <= wbps_pkg::LEN_REG_W'(1);
         s1_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         count_ff              <= '0;
         reported_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         reported_ff  <= reported_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
      win_ff      <= win_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall raised with empty input register");

   a_not_found_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |->
         (rsp_payload.match_offset == '0) && !rsp_payload.offset_overflow)
      else $error("not-found response carries offset or overflow");

   a_region_end_clears: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_data_ff.region_end |=> (count_ff == '0) && !reported_ff)
      else $error("region state not cleared after region end");

   a_hit_sets_reported: assert property (@(posedge clock) disable iff (reset)
      s1_fire && hit && !s1_data_ff.region_end |=> reported_ff)
      else $error("match not recorded");

   a_no_rsp_after_match: assert property (@(posedge clock) disable iff (reset)
      s1_fire && reported_ff && !(rsp_valid_ff && rsp_stall) |=> !rsp_valid_ff)
      else $error("response produced after match already reported");
`endif

endmodule

// ----- dv/wbps_checker.sv -----
module wbps_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  wbps_pkg::req_payload_type        req_payload,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  wbps_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_write_en,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatch_count,
   output int                               reports_due,
   output int                               bytes_scanned
);

   localparam int WINDOW_DEPTH = 15;
   localparam int MAX_LEN      = 16;

   logic [wbps_pkg::CSR_DATA_W-1:0] pattern_low;
   logic [wbps_pkg::CSR_DATA_W-1:0] pattern_high;
   logic [wbps_pkg::MASK_W-1:0]     wild_mask;
   logic [wbps_pkg::LEN_REG_W-1:0]  length_reg;

   // window[0] holds the byte just before the current one
   logic [wbps_pkg::DATA_W-1:0]     window [WINDOW_DEPTH];
   logic [31:0]                     byte_count;
   logic                            match_done;

   wbps_pkg::rsp_payload_type       expected_reports [$];

   task automatic clear_region();
      window     = '{default: '0};
      byte_count = '0;
      match_done = 1'b0;
   endtask

   task automatic scan_byte(input logic [wbps_pkg::DATA_W-1:0] b_in, input logic last);
      int unsigned                         len;
      int unsigned                         back;
      logic [31:0]                         idx;
      logic                                hit;
      logic [wbps_pkg::DATA_W-1:0]         seen;
      logic [2*wbps_pkg::CSR_DATA_W-1:0]   pattern_all;
      wbps_pkg::rsp_payload_type           res;
      len = length_reg;
      if (len < 1) len = 1;
      if (len > MAX_LEN) len = MAX_LEN;
      idx = byte_count;
      pattern_all = {pattern_high, pattern_low};
      // every accepted byte counts toward the run length
      bytes_scanned++;
      // after a match the rest of the region is dropped; its end only clears
      if (match_done) begin
         if (last) clear_region();
         return;
      end
      hit = 1'b0;
      if (idx >= len - 1) begin
         hit = 1'b1;
         for (int i = 0; i < len; i++) begin
            back = len - 1 - i;
            seen = (back == 0) ? b_in : window[back - 1];
            if (!wild_mask[i] && seen != pattern_all[i*wbps_pkg::DATA_W +: wbps_pkg::DATA_W])
               hit = 1'b0;
         end
      end
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b_in;
      if (byte_count != 32'hFFFF_FFFF) byte_count++;
      if (hit) begin
         res.found           = 1'b1;
         res.match_offset    = idx - 32'(len - 1);
         res.offset_overflow = (idx == 32'hFFFF_FFFF);
         expected_reports.push_back(res);
         if (last) clear_region();
         else match_done = 1'b1;
      end else if (last) begin
         res = '0;
         expected_reports.push_back(res);
         clear_region();
      end
   endtask

   task automatic check_report(input wbps_pkg::rsp_payload_type got);
      wbps_pkg::rsp_payload_type want;
      if (expected_reports.size() == 0) begin
         $display("%0t: unexpected transaction, expected none, actual found=%0b offset=%0d ovf=%0b",
                  $time, got.found, got.match_offset, got.offset_overflow);
         mismatch_count++;
         return;
      end
      want = expected_reports.pop_front();
      if (got.found !== want.found) begin
         $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, got.found);
         mismatch_count++;
      end
      if (got.match_offset !== want.match_offset) begin
         $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                  $time, want.match_offset, got.match_offset);
         mismatch_count++;
      end
      if (got.offset_overflow !== want.offset_overflow) begin
         $display("%0t: offset_overflow mismatch, expected %0b, actual %0b",
                  $time, want.offset_overflow, got.offset_overflow);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_low  = '0;
         pattern_high = '0;
         wild_mask    = '0;
         length_reg   = wbps_pkg::LEN_REG_W'(1);
         clear_region();
         expected_reports.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               wbps_pkg::CSR_PATTERN_LOW:  pattern_low  = csr_wdata;
               wbps_pkg::CSR_PATTERN_HIGH: pattern_high = csr_wdata;
               wbps_pkg::CSR_WILDCARD:     wild_mask    = csr_wdata[wbps_pkg::MASK_W-1:0];
               wbps_pkg::CSR_LENGTH:       length_reg   = csr_wdata[wbps_pkg::LEN_REG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            scan_byte(req_payload.data_byte, req_payload.region_end);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            check_report(rsp_payload);
         end
      end
      reports_due = expected_reports.size();
   end

endmodule

// ----- dv/testbench.sv -----
module testbench;

   localparam int ITEM_TARGET  = 470;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 6;

   logic                             clock        = 1'b0;
   logic                             reset        = 1'b1;
   logic                             req_valid    = 1'b0;
   logic                             req_stall;
   wbps_pkg::req_payload_type        req_payload  = '0;
   logic                             rsp_valid;
   logic                             rsp_stall    = 1'b0;
   wbps_pkg::rsp_payload_type        rsp_payload;
   logic                             csr_write_en = 1'b0;
   logic [wbps_pkg::CSR_INDEX_W-1:0] csr_index    = wbps_pkg::CSR_PATTERN_LOW;
   logic [wbps_pkg::CSR_DATA_W-1:0]  csr_wdata    = '0;

   int mismatch_count;
   int reports_due;
   int bytes_scanned;

   // stimulus-side copy of the signature, used to plant matches
   logic [wbps_pkg::CSR_DATA_W-1:0] cfg_low  = '0;
   logic [wbps_pkg::CSR_DATA_W-1:0] cfg_high = '0;
   logic [wbps_pkg::MASK_W-1:0]     cfg_mask = '0;
   int                              cfg_len  = 1;

   bit no_gaps    = 1'b0;
   bit rsp_calm   = 1'b0;
   bit hold_start = 1'b0;

   wildcard_byte_pattern_search_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   wbps_checker scan_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .reports_due    (reports_due),
      .bytes_scanned  (bytes_scanned)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // called and returns at a rising edge
   task automatic send_byte(input logic [wbps_pkg::DATA_W-1:0] value, input logic last);
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: value, region_end: last};
      do @(posedge clock); while (req_stall !== 1'b0);
      if (!no_gaps && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (reports_due == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [wbps_pkg::CSR_DATA_W-1:0] lo,
                            input logic [wbps_pkg::CSR_DATA_W-1:0] hi,
                            input logic [wbps_pkg::CSR_DATA_W-1:0] mask_data,
                            input logic [wbps_pkg::CSR_DATA_W-1:0] len_data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= wbps_pkg::CSR_PATTERN_LOW;
      csr_wdata    <= lo;
      @(posedge clock);
      csr_index    <= wbps_pkg::CSR_PATTERN_HIGH;
      csr_wdata    <= hi;
      @(posedge clock);
      csr_index    <= wbps_pkg::CSR_WILDCARD;
      csr_wdata    <= mask_data;
      @(posedge clock);
      csr_index    <= wbps_pkg::CSR_LENGTH;
      csr_wdata    <= len_data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_low  = lo;
      cfg_high = hi;
      cfg_mask = mask_data[wbps_pkg::MASK_W-1:0];
      cfg_len  = int'(len_data[wbps_pkg::LEN_REG_W-1:0]);
      if (cfg_len < 1) cfg_len = 1;
      if (cfg_len > 16) cfg_len = 16;
   endtask

   // random bytes biased toward signature bytes, optionally with one planted copy
   task automatic send_region(input int n, input bit plant);
      logic [wbps_pkg::DATA_W-1:0]       region_q [$];
      logic [2*wbps_pkg::CSR_DATA_W-1:0] pattern_all;
      int                                start;
      pattern_all = {cfg_high, cfg_low};
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1)) region_q.push_back(wbps_pkg::DATA_W'($urandom));
         else region_q.push_back(
            pattern_all[$urandom_range(cfg_len - 1)*wbps_pkg::DATA_W +: wbps_pkg::DATA_W]);
      end
      if (plant && n >= cfg_len) begin
         start = $urandom_range(n - cfg_len);
         for (int j = 0; j < cfg_len; j++) begin
            if (!cfg_mask[j])
               region_q[start + j] = pattern_all[j*wbps_pkg::DATA_W +: wbps_pkg::DATA_W];
         end
      end
      foreach (region_q[i]) send_byte(region_q[i], i == n - 1);
   endtask

   // receiver: random stall, calm stretch, or a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_start && hold_left == 0) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !rsp_calm && ($urandom_range(99) < 35);
         end
      end
   end

   initial begin
      int                              phase;
      int                              region_len;
      logic [wbps_pkg::LEN_REG_W-1:0]  len_val;
      logic [wbps_pkg::MASK_W-1:0]     mask_val;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset signature is a single zero byte
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);   // match on the last byte
      send_byte(8'hFF, 1'b1);   // not found
      send_byte(8'hAB, 1'b0);
      send_byte(8'h00, 1'b0);   // match, then trailing bytes dropped
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b1);
      drain();

      // FF ? 80, junk above the register widths
      configure(64'h0000_0000_0080_00FF, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_0002, 64'hFFFF_FFFF_FFFF_FFE3);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'hFF, 1'b0);   // region shorter than the signature
      send_byte(8'h33, 1'b1);
      drain();

      // zero length behaves as one
      configure(64'h0000_0000_0000_005A, 64'h0, 64'h0, 64'h0);
      send_byte(8'h5A, 1'b1);
      send_byte(8'hA5, 1'b1);

      phase = 0;
      while (bytes_scanned < ITEM_TARGET) begin
         drain();
         case ($urandom_range(4))
            0:       len_val = wbps_pkg::LEN_REG_W'($urandom_range(1, 3));
            1, 2:    len_val = wbps_pkg::LEN_REG_W'($urandom_range(4, 10));
            3:       len_val = wbps_pkg::LEN_REG_W'($urandom_range(11, 16));
            default: len_val = wbps_pkg::LEN_REG_W'($urandom_range(0, 31));
         endcase
         case ($urandom_range(3))
            0:       mask_val = '0;
            1:       mask_val = '1;
            default: mask_val = wbps_pkg::MASK_W'($urandom) & wbps_pkg::MASK_W'($urandom);
         endcase
         if (phase == 2) begin
            mask_val = '1;
            len_val  = wbps_pkg::LEN_REG_W'(2);
         end
         if (phase == 3) len_val = wbps_pkg::LEN_REG_W'(31);
         if (phase == 4) begin
            len_val  = wbps_pkg::LEN_REG_W'(16);
            mask_val = '0;
         end
         configure({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, 16'($urandom), mask_val}, {$urandom, 27'($urandom), len_val});
         no_gaps  = (phase == 1 || phase == 2);
         rsp_calm = (phase == 1);
         // every short region reports here, so the hold-off backs up the input
         if (phase == 2) hold_start = 1'b1;
         for (int r = 0; r < 8; r++) begin
            if (phase == 2) region_len = $urandom_range(1, 3);
            else if ($urandom_range(9) == 0) region_len = $urandom_range(1, 64);
            else region_len = $urandom_range(1, cfg_len + 10);
            send_region(region_len, $urandom_range(99) < 60);
         end
         no_gaps  = 1'b0;
         rsp_calm = 1'b0;
         phase++;
      end
      drain();

      if (mismatch_count == 0 && reports_due == 0) begin
         $display("wildcard_byte_pattern_search_unit regression: pass");
      end else begin
         $display("wildcard_byte_pattern_search_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("wildcard_byte_pattern_search_unit regression: fail");
      $finish;
   end

endmodule
